[rtl/obbt_pkg.sv]
// Shared widths, payload types and the mid-pipeline word of the box overlap test.
`timescale 1ns / 1ps

package obbt_pkg;

  // Field widths of the input word
  localparam int CW = 24;  // centre coordinate, Q.8 metres
  localparam int TW = 16;  // heading cosine / sine, Q1.15
  localparam int HW = 16;  // half length / half width, Q.8 metres

  // Derived datapath widths
  localparam int SXW    = CW + 1;       // centre offset
  localparam int TPW    = 2 * TW;       // trig x trig product
  localparam int PW     = TPW;          // magnitude of a heading dot / cross term
  localparam int BPW    = TW + HW;      // trig x half-size product
  localparam int EXW    = BPW + 1;      // corner extent from the centre
  localparam int LPW    = SXW + TW;     // offset x trig product and its sum
  localparam int RPW    = HW + PW;      // half-size x dot / cross product
  localparam int RW     = RPW + 2;      // right-hand side of one axis test
  localparam int LHS_SH = TW - 1;       // Q1.15 scale on the offset projection
  localparam int OWN_SH = 2 * (TW - 1); // scale on the box's own half extent
  localparam int BW     = CW + TW;      // corner bound at scale 2^-23 m
  localparam int CMPW   = LPW + LHS_SH; // width of the axis comparison

  // Input word: two boxes
  typedef struct packed {
    logic signed [CW-1:0] a_center_x;
    logic signed [CW-1:0] a_center_y;
    logic signed [TW-1:0] a_cos;
    logic signed [TW-1:0] a_sin;
    logic        [HW-1:0] a_half_length;
    logic        [HW-1:0] a_half_width;
    logic signed [CW-1:0] b_center_x;
    logic signed [CW-1:0] b_center_y;
    logic signed [TW-1:0] b_cos;
    logic signed [TW-1:0] b_sin;
    logic        [HW-1:0] b_half_length;
    logic        [HW-1:0] b_half_width;
  } obbt_in_t;

  // Result word
  typedef struct packed {
    logic overlap;
  } obbt_out_t;

  // Word handed from the product stages to the test stages
  typedef struct packed {
    logic        [PW-1:0]  p;      // |cos_a cos_b + sin_a sin_b|
    logic        [PW-1:0]  q;      // |cos_a sin_b - sin_a cos_b|
    logic signed [LPW-1:0] a1x;    // sx * cos_a
    logic signed [LPW-1:0] a1y;    // sy * sin_a
    logic signed [LPW-1:0] a2x;    // sx * sin_a
    logic signed [LPW-1:0] a2y;    // sy * cos_a
    logic signed [LPW-1:0] b1x;    // sx * cos_b
    logic signed [LPW-1:0] b1y;    // sy * sin_b
    logic signed [LPW-1:0] b2x;    // sx * sin_b
    logic signed [LPW-1:0] b2y;    // sy * cos_b
    logic        [EXW-1:0] ex_ax;  // x extent of box A corners
    logic        [EXW-1:0] ex_ay;
    logic        [EXW-1:0] ex_bx;
    logic        [EXW-1:0] ex_by;
    logic signed [CW-1:0]  a_cx;
    logic signed [CW-1:0]  a_cy;
    logic signed [CW-1:0]  b_cx;
    logic signed [CW-1:0]  b_cy;
    logic        [HW-1:0]  a_hl;
    logic        [HW-1:0]  a_hw;
    logic        [HW-1:0]  b_hl;
    logic        [HW-1:0]  b_hw;
  } obbt_mid_t;

endpackage

[rtl/obbt_in_if.sv]
// Valid/ready channel carrying one pair of boxes.
`timescale 1ns / 1ps

interface obbt_in_if;
  logic               valid;
  logic               ready;
  obbt_pkg::obbt_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/obbt_out_if.sv]
// Valid/ready channel carrying one overlap result.
`timescale 1ns / 1ps

interface obbt_out_if;
  logic                valid;
  logic                ready;
  obbt_pkg::obbt_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/obbt_prep.sv]
// Stages 1 and 2: centre offset, heading and extent products, offset projections.
`timescale 1ns / 1ps

module obbt_prep (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  obbt_pkg::obbt_in_t   data_i,
  output logic                 valid_o,
  output obbt_pkg::obbt_mid_t  mid_o
);

  function automatic logic [obbt_pkg::BPW-1:0] mag_b(
    input logic signed [obbt_pkg::BPW-1:0] v
  );
    mag_b = v[obbt_pkg::BPW-1] ? -v : v;
  endfunction

  // ---------------- stage 1 ----------------
  logic                                v1_q;
  obbt_pkg::obbt_in_t                  in1_q;
  logic signed [obbt_pkg::SXW-1:0]     sx_d, sy_d, sx_q, sy_q;
  logic signed [obbt_pkg::TPW-1:0]     cc_d, ss_d, cs_d, sc_d;
  logic signed [obbt_pkg::TPW-1:0]     cc_q, ss_q, cs_q, sc_q;
  logic signed [obbt_pkg::BPW-1:0]     a_chl_d, a_shw_d, a_shl_d, a_chw_d;
  logic signed [obbt_pkg::BPW-1:0]     b_chl_d, b_shw_d, b_shl_d, b_chw_d;
  logic signed [obbt_pkg::BPW-1:0]     a_chl_q, a_shw_q, a_shl_q, a_chw_q;
  logic signed [obbt_pkg::BPW-1:0]     b_chl_q, b_shw_q, b_shl_q, b_chw_q;

  // Centre offset of B from A
  assign sx_d = $signed({data_i.b_center_x[obbt_pkg::CW-1], data_i.b_center_x})
              - $signed({data_i.a_center_x[obbt_pkg::CW-1], data_i.a_center_x});
  assign sy_d = $signed({data_i.b_center_y[obbt_pkg::CW-1], data_i.b_center_y})
              - $signed({data_i.a_center_y[obbt_pkg::CW-1], data_i.a_center_y});

  // Heading cross products: every axis test reduces to these four
  assign cc_d = data_i.a_cos * data_i.b_cos;
  assign ss_d = data_i.a_sin * data_i.b_sin;
  assign cs_d = data_i.a_cos * data_i.b_sin;
  assign sc_d = data_i.a_sin * data_i.b_cos;

  // Corner offsets along x and y for each box
  assign a_chl_d = data_i.a_cos * $signed({1'b0, data_i.a_half_length});
  assign a_shw_d = data_i.a_sin * $signed({1'b0, data_i.a_half_width});
  assign a_shl_d = data_i.a_sin * $signed({1'b0, data_i.a_half_length});
  assign a_chw_d = data_i.a_cos * $signed({1'b0, data_i.a_half_width});
  assign b_chl_d = data_i.b_cos * $signed({1'b0, data_i.b_half_length});
  assign b_shw_d = data_i.b_sin * $signed({1'b0, data_i.b_half_width});
  assign b_shl_d = data_i.b_sin * $signed({1'b0, data_i.b_half_length});
  assign b_chw_d = data_i.b_cos * $signed({1'b0, data_i.b_half_width});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in1_q   <= data_i;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      cc_q    <= cc_d;
      ss_q    <= ss_d;
      cs_q    <= cs_d;
      sc_q    <= sc_d;
      a_chl_q <= a_chl_d;
      a_shw_q <= a_shw_d;
      a_shl_q <= a_shl_d;
      a_chw_q <= a_chw_d;
      b_chl_q <= b_chl_d;
      b_shw_q <= b_shw_d;
      b_shl_q <= b_shl_d;
      b_chw_q <= b_chw_d;
    end
  end

  // ---------------- stage 2 ----------------
  logic                            v2_q;
  obbt_pkg::obbt_mid_t             mid_d, mid_q;
  logic signed [obbt_pkg::TPW:0]   dot_s, crs_s, dot_abs, crs_abs;

  // Dot and cross of the two headings, as magnitudes
  assign dot_s   = $signed({cc_q[obbt_pkg::TPW-1], cc_q})
                 + $signed({ss_q[obbt_pkg::TPW-1], ss_q});
  assign crs_s   = $signed({cs_q[obbt_pkg::TPW-1], cs_q})
                 - $signed({sc_q[obbt_pkg::TPW-1], sc_q});
  assign dot_abs = dot_s[obbt_pkg::TPW] ? -dot_s : dot_s;
  assign crs_abs = crs_s[obbt_pkg::TPW] ? -crs_s : crs_s;

  always_comb begin
    mid_d       = '0;
    mid_d.p     = dot_abs[obbt_pkg::PW-1:0];
    mid_d.q     = crs_abs[obbt_pkg::PW-1:0];
    // Centre offset projected onto the four axes, in halves
    mid_d.a1x   = sx_q * in1_q.a_cos;
    mid_d.a1y   = sy_q * in1_q.a_sin;
    mid_d.a2x   = sx_q * in1_q.a_sin;
    mid_d.a2y   = sy_q * in1_q.a_cos;
    mid_d.b1x   = sx_q * in1_q.b_cos;
    mid_d.b1y   = sy_q * in1_q.b_sin;
    mid_d.b2x   = sx_q * in1_q.b_sin;
    mid_d.b2y   = sy_q * in1_q.b_cos;
    // Corner extents: the four corners span centre +/- (|dx1| + |dx2|)
    mid_d.ex_ax = {1'b0, mag_b(a_chl_q)} + {1'b0, mag_b(a_shw_q)};
    mid_d.ex_ay = {1'b0, mag_b(a_shl_q)} + {1'b0, mag_b(a_chw_q)};
    mid_d.ex_bx = {1'b0, mag_b(b_chl_q)} + {1'b0, mag_b(b_shw_q)};
    mid_d.ex_by = {1'b0, mag_b(b_shl_q)} + {1'b0, mag_b(b_chw_q)};
    mid_d.a_cx  = in1_q.a_center_x;
    mid_d.a_cy  = in1_q.a_center_y;
    mid_d.b_cx  = in1_q.b_center_x;
    mid_d.b_cy  = in1_q.b_center_y;
    mid_d.a_hl  = in1_q.a_half_length;
    mid_d.a_hw  = in1_q.a_half_width;
    mid_d.b_hl  = in1_q.b_half_length;
    mid_d.b_hw  = in1_q.b_half_width;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= mid_d;
    end
  end

  assign valid_o = v2_q;
  assign mid_o   = mid_q;

  // Valid bits move one stage per advance
  a_v2_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> (v2_q == $past(v1_q)))
    else $error("stage 2 valid did not follow stage 1");

endmodule

[rtl/obbt_test.sv]
// Stages 3 to 5: bounding-box reject, separating-axis sums and final compare.
`timescale 1ns / 1ps

module obbt_test (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  obbt_pkg::obbt_mid_t mid_i,
  output logic                valid_o,
  output logic                overlap_o
);

  function automatic logic [obbt_pkg::LPW-1:0] mag_l(
    input logic signed [obbt_pkg::LPW-1:0] v
  );
    mag_l = v[obbt_pkg::LPW-1] ? -v : v;
  endfunction

  // ---------------- stage 3 ----------------
  logic                              v3_q;
  logic signed [obbt_pkg::LPW-1:0]   s_a1, s_a2, s_b1, s_b2;
  logic        [obbt_pkg::LPW-1:0]   l_a1_q, l_a2_q, l_b1_q, l_b2_q;
  logic        [obbt_pkg::RPW-1:0]   r_blp_q, r_bwq_q, r_blq_q, r_bwp_q;
  logic        [obbt_pkg::RPW-1:0]   r_alp_q, r_awq_q, r_alq_q, r_awp_q;
  logic        [obbt_pkg::HW-1:0]    a_hl_q, a_hw_q, b_hl_q, b_hw_q;
  logic signed [obbt_pkg::BW-1:0]    a_bx, a_by, b_bx, b_by;
  logic signed [obbt_pkg::BW-1:0]    a_ex, a_ey, b_ex, b_ey;
  logic signed [obbt_pkg::BW-1:0]    a_minx_q, a_maxx_q, a_miny_q, a_maxy_q;
  logic signed [obbt_pkg::BW-1:0]    b_minx_q, b_maxx_q, b_miny_q, b_maxy_q;

  // Offset projections on the four axes
  assign s_a1 = mid_i.a1x + mid_i.a1y;
  assign s_a2 = mid_i.a2x - mid_i.a2y;
  assign s_b1 = mid_i.b1x + mid_i.b1y;
  assign s_b2 = mid_i.b2x - mid_i.b2y;

  // Centres at the corner scale and extents widened to match
  assign a_bx = $signed({mid_i.a_cx[obbt_pkg::CW-1], mid_i.a_cx, {obbt_pkg::LHS_SH{1'b0}}});
  assign a_by = $signed({mid_i.a_cy[obbt_pkg::CW-1], mid_i.a_cy, {obbt_pkg::LHS_SH{1'b0}}});
  assign b_bx = $signed({mid_i.b_cx[obbt_pkg::CW-1], mid_i.b_cx, {obbt_pkg::LHS_SH{1'b0}}});
  assign b_by = $signed({mid_i.b_cy[obbt_pkg::CW-1], mid_i.b_cy, {obbt_pkg::LHS_SH{1'b0}}});
  assign a_ex = $signed({{(obbt_pkg::BW-obbt_pkg::EXW){1'b0}}, mid_i.ex_ax});
  assign a_ey = $signed({{(obbt_pkg::BW-obbt_pkg::EXW){1'b0}}, mid_i.ex_ay});
  assign b_ex = $signed({{(obbt_pkg::BW-obbt_pkg::EXW){1'b0}}, mid_i.ex_bx});
  assign b_ey = $signed({{(obbt_pkg::BW-obbt_pkg::EXW){1'b0}}, mid_i.ex_by});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l_a1_q   <= mag_l(s_a1);
      l_a2_q   <= mag_l(s_a2);
      l_b1_q   <= mag_l(s_b1);
      l_b2_q   <= mag_l(s_b2);
      // Other box's projected half extents, from heading dot / cross
      r_blp_q  <= mid_i.b_hl * mid_i.p;
      r_bwq_q  <= mid_i.b_hw * mid_i.q;
      r_blq_q  <= mid_i.b_hl * mid_i.q;
      r_bwp_q  <= mid_i.b_hw * mid_i.p;
      r_alp_q  <= mid_i.a_hl * mid_i.p;
      r_awq_q  <= mid_i.a_hw * mid_i.q;
      r_alq_q  <= mid_i.a_hl * mid_i.q;
      r_awp_q  <= mid_i.a_hw * mid_i.p;
      a_hl_q   <= mid_i.a_hl;
      a_hw_q   <= mid_i.a_hw;
      b_hl_q   <= mid_i.b_hl;
      b_hw_q   <= mid_i.b_hw;
      a_minx_q <= a_bx - a_ex;
      a_maxx_q <= a_bx + a_ex;
      a_miny_q <= a_by - a_ey;
      a_maxy_q <= a_by + a_ey;
      b_minx_q <= b_bx - b_ex;
      b_maxx_q <= b_bx + b_ex;
      b_miny_q <= b_by - b_ey;
      b_maxy_q <= b_by + b_ey;
    end
  end

  // ---------------- stage 4 ----------------
  logic                           v4_q;
  logic                           aabb_d, aabb_q;
  logic [obbt_pkg::RW-1:0]        r_a1_d, r_a2_d, r_b1_d, r_b2_d;
  logic [obbt_pkg::RW-1:0]        r_a1_q, r_a2_q, r_b1_q, r_b2_q;
  logic [obbt_pkg::LPW-1:0]       l4_a1_q, l4_a2_q, l4_b1_q, l4_b2_q;

  // Axis-aligned reject on the corner bounds, touching counts as overlap
  assign aabb_d = !(b_maxx_q < a_minx_q || b_minx_q > a_maxx_q ||
                    b_maxy_q < a_miny_q || b_miny_q > a_maxy_q);

  // Right-hand sides: other box's extents plus own half extent
  assign r_a1_d = {2'b00, r_blp_q} + {2'b00, r_bwq_q}
                + {{(obbt_pkg::RW-obbt_pkg::HW-obbt_pkg::OWN_SH){1'b0}},
                   a_hl_q, {obbt_pkg::OWN_SH{1'b0}}};
  assign r_a2_d = {2'b00, r_blq_q} + {2'b00, r_bwp_q}
                + {{(obbt_pkg::RW-obbt_pkg::HW-obbt_pkg::OWN_SH){1'b0}},
                   a_hw_q, {obbt_pkg::OWN_SH{1'b0}}};
  assign r_b1_d = {2'b00, r_alp_q} + {2'b00, r_awq_q}
                + {{(obbt_pkg::RW-obbt_pkg::HW-obbt_pkg::OWN_SH){1'b0}},
                   b_hl_q, {obbt_pkg::OWN_SH{1'b0}}};
  assign r_b2_d = {2'b00, r_alq_q} + {2'b00, r_awp_q}
                + {{(obbt_pkg::RW-obbt_pkg::HW-obbt_pkg::OWN_SH){1'b0}},
                   b_hw_q, {obbt_pkg::OWN_SH{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      aabb_q  <= aabb_d;
      r_a1_q  <= r_a1_d;
      r_a2_q  <= r_a2_d;
      r_b1_q  <= r_b1_d;
      r_b2_q  <= r_b2_d;
      l4_a1_q <= l_a1_q;
      l4_a2_q <= l_a2_q;
      l4_b1_q <= l_b1_q;
      l4_b2_q <= l_b2_q;
    end
  end

  // ---------------- stage 5 ----------------
  logic v5_q;
  logic ovl_d, ovl_q;
  logic ok_a1, ok_a2, ok_b1, ok_b2;

  // Inclusive separating-axis compares
  assign ok_a1 = {l4_a1_q, {obbt_pkg::LHS_SH{1'b0}}}
              <= {{(obbt_pkg::CMPW-obbt_pkg::RW){1'b0}}, r_a1_q};
  assign ok_a2 = {l4_a2_q, {obbt_pkg::LHS_SH{1'b0}}}
              <= {{(obbt_pkg::CMPW-obbt_pkg::RW){1'b0}}, r_a2_q};
  assign ok_b1 = {l4_b1_q, {obbt_pkg::LHS_SH{1'b0}}}
              <= {{(obbt_pkg::CMPW-obbt_pkg::RW){1'b0}}, r_b1_q};
  assign ok_b2 = {l4_b2_q, {obbt_pkg::LHS_SH{1'b0}}}
              <= {{(obbt_pkg::CMPW-obbt_pkg::RW){1'b0}}, r_b2_q};
  assign ovl_d = aabb_q && ok_a1 && ok_a2 && ok_b1 && ok_b2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovl_q <= ovl_d;
    end
  end

  assign valid_o   = v5_q;
  assign overlap_o = ovl_q;

  // A bounding-box reject always ends as no overlap
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && v4_q && !aabb_q) |=> !overlap_o)
    else $error("bounding-box reject produced an overlap");

  // Output valid follows stage 4 on each advance
  a_v5_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> (valid_o == $past(v4_q)))
    else $error("output valid did not follow stage 4");

endmodule

[rtl/oriented_box_overlap_test_unit.sv]
// Top level of the oriented box overlap test pipeline.
`timescale 1ns / 1ps

// Overlap test for two oriented 2D boxes (centre in Q.8 metres, heading as a
// Q1.15 cosine/sine pair, half length and half width in Q.8 metres). Each
// input word gives one result word: overlap is 1 when the boxes touch or
// overlap. The test is an axis-aligned reject on the corner bounds followed by
// the separating-axis test on all four box axes, exact with no rounding. The
// block is a five-stage pipeline: a word may be taken every cycle while the
// stages advance, and its result is offered from the stage 5 output register.
// The stages advance together whenever the output register is empty or being
// taken, so ready on the input follows ready on the output in the same cycle.

module oriented_box_overlap_test_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  obbt_in_if.sink   in_i,
  obbt_out_if.source out_o
);

  logic                adv;
  logic                mid_v;
  obbt_pkg::obbt_mid_t mid;
  logic                res_v;
  logic                res_ovl;

  // Whole pipeline moves when the output slot frees up
  assign adv        = !res_v || out_o.ready;
  assign in_i.ready = adv;

  obbt_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_i.valid),
    .data_i  (in_i.data),
    .valid_o (mid_v),
    .mid_o   (mid)
  );

  obbt_test u_test (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .valid_i   (mid_v),
    .mid_i     (mid),
    .valid_o   (res_v),
    .overlap_o (res_ovl)
  );

  assign out_o.valid        = res_v;
  assign out_o.data.overlap = res_ovl;

  // An empty output slot never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with an empty output register");

endmodule

[tb/sv/obbt_overlap_checker.sv]
// Checker for the oriented box overlap test: predicts each overlap bit and compares.
`timescale 1ns / 1ps

module obbt_overlap_checker
  import obbt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  obbt_in_if   pair_mon,
  obbt_out_if  res_mon,
  output int   error_count_o,
  output int   outstanding_o
);

  // One box widened to 64 bits; centre and halves in Q.8, heading in Q1.15
  typedef struct {
    longint cx;
    longint cy;
    longint c;
    longint s;
    longint hl;
    longint hw;
  } box_t;

  // Overlap bits still owed by the block, oldest first
  logic expected_overlap_q[$];

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic box_t widen_box(logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                                     logic signed [TW-1:0] c, logic signed [TW-1:0] s,
                                     logic [HW-1:0] hl, logic [HW-1:0] hw);
    box_t b;
    b.cx = longint'(cx);
    b.cy = longint'(cy);
    b.c  = longint'(c);
    b.s  = longint'(s);
    b.hl = longint'(hl);
    b.hw = longint'(hw);
    return b;
  endfunction

  // Corner reach from the centre, scale 2^-23 m. The four corners take every
  // sign combination of the two half vectors, so the bounds are centre +/- reach.
  function automatic longint reach_x(box_t b);
    return mag(b.c * b.hl) + mag(b.s * b.hw);
  endfunction

  function automatic longint reach_y(box_t b);
    return mag(b.s * b.hl) + mag(b.c * b.hw);
  endfunction

  // Inclusive projection test on one axis (ux, uy) of a box; q is the other box
  function automatic logic axis_meets(longint ux, longint uy, longint own_half, box_t q,
                                      longint sx, longint sy);
    longint lhs;
    longint rhs;
    lhs = mag(sx * ux + sy * uy) * 32768;
    rhs = q.hl * mag(q.c * ux + q.s * uy) + q.hw * mag(q.s * ux - q.c * uy)
          + (own_half <<< 30);
    return lhs <= rhs;
  endfunction

  // Overlap of the two boxes: bounding-box reject, then four separating axes
  function automatic logic boxes_meet(obbt_in_t w);
    box_t   a;
    box_t   b;
    longint ax;
    longint ay;
    longint bx;
    longint by;
    longint arx;
    longint ary;
    longint brx;
    longint bry;
    longint sx;
    longint sy;
    a = widen_box(w.a_center_x, w.a_center_y, w.a_cos, w.a_sin,
                  w.a_half_length, w.a_half_width);
    b = widen_box(w.b_center_x, w.b_center_y, w.b_cos, w.b_sin,
                  w.b_half_length, w.b_half_width);
    ax  = a.cx * 32768;
    ay  = a.cy * 32768;
    bx  = b.cx * 32768;
    by  = b.cy * 32768;
    arx = reach_x(a);
    ary = reach_y(a);
    brx = reach_x(b);
    bry = reach_y(b);
    if (bx + brx < ax - arx || bx - brx > ax + arx ||
        by + bry < ay - ary || by - bry > ay + ary) begin
      return 1'b0;
    end
    sx = b.cx - a.cx;
    sy = b.cy - a.cy;
    return axis_meets(a.c, a.s, a.hl, b, sx, sy) &&
           axis_meets(a.s, -a.c, a.hw, b, sx, sy) &&
           axis_meets(b.c, b.s, b.hl, a, sx, sy) &&
           axis_meets(b.s, -b.c, b.hw, a, sx, sy);
  endfunction

  // Sample at the falling edge: the channels are steady until the next rising
  // edge, where a word with valid and ready high is taken
  always @(negedge clk_i) begin : watch
    logic want;
    if (!rst_ni) begin
      expected_overlap_q.delete();
      error_count_o = 0;
    end else begin
      if (pair_mon.valid && pair_mon.ready) begin
        expected_overlap_q.push_back(boxes_meet(pair_mon.data));
      end
      if (res_mon.valid && res_mon.ready) begin
        if (expected_overlap_q.size() == 0) begin
          $error("overlap: no word outstanding, actual %0b", res_mon.data.overlap);
          error_count_o = error_count_o + 1;
        end else begin
          want = expected_overlap_q.pop_front();
          if (res_mon.data.overlap !== want) begin
            $error("overlap: expected %0b, actual %0b", want, res_mon.data.overlap);
            error_count_o = error_count_o + 1;
          end
        end
      end
    end
    outstanding_o = expected_overlap_q.size();
  end

endmodule

[tb/sv/oriented_box_overlap_test_unit_tb.sv]
// Testbench top for the oriented box overlap test: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module oriented_box_overlap_test_unit_tb;
  import obbt_pkg::*;

  localparam int QUIET_LIMIT = 2000;  // cycles with no word taken before giving up
  localparam int IDLE_PCT    = 22;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   error_count;
  int   outstanding;
  int   sent_count  = 0;
  int   cycle_count = 0;
  int   quiet_cycles = 0;

  obbt_in_if  pair_if ();
  obbt_out_if res_if ();

  oriented_box_overlap_test_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pair_if),
    .out_o  (res_if)
  );

  obbt_overlap_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pair_mon      (pair_if),
    .res_mon       (res_if),
    .error_count_o (error_count),
    .outstanding_o (outstanding)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Result side back-pressure, with a stall-free stretch
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (cycle_count >= 600 && cycle_count < 1000) begin
      res_if.ready <= 1'b1;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: too long without any word taken on either side
  always @(negedge clk_i) begin
    if (!rst_ni || (pair_if.valid && pair_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("oriented_box_overlap_test_unit_tb: errors");
      $finish;
    end
  end

  // Offer one pair of boxes; called and returns at a rising edge
  task automatic send_pair(input obbt_in_t w);
    logic taken;
    while (!(sent_count >= 250 && sent_count < 420) &&
           $urandom_range(0, 99) < IDLE_PCT) begin
      pair_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pair_if.valid <= 1'b1;
    pair_if.data  <= w;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = pair_if.ready;
      @(posedge clk_i);
    end
    sent_count = sent_count + 1;
  endtask

  function automatic obbt_in_t mk_pair(int a_cx, int a_cy, int a_c, int a_s, int a_hl,
                                       int a_hw, int b_cx, int b_cy, int b_c, int b_s,
                                       int b_hl, int b_hw);
    obbt_in_t w;
    w.a_center_x    = CW'(a_cx);
    w.a_center_y    = CW'(a_cy);
    w.a_cos         = TW'(a_c);
    w.a_sin         = TW'(a_s);
    w.a_half_length = HW'(a_hl);
    w.a_half_width  = HW'(a_hw);
    w.b_center_x    = CW'(b_cx);
    w.b_center_y    = CW'(b_cy);
    w.b_cos         = TW'(b_c);
    w.b_sin         = TW'(b_s);
    w.b_half_length = HW'(b_hl);
    w.b_half_width  = HW'(b_hw);
    return w;
  endfunction

  // Unit-length heading at a random angle, Q1.15
  function automatic void unit_heading(output logic signed [TW-1:0] c,
                                       output logic signed [TW-1:0] s);
    real th;
    th = real'($urandom_range(0, 35999)) * 3.14159265358979 / 18000.0;
    c  = TW'($rtoi($cos(th) * 32767.0));
    s  = TW'($rtoi($sin(th) * 32767.0));
  endfunction

  // Random pair: mostly neighbouring boxes so both verdicts are common
  function automatic obbt_in_t random_pair();
    obbt_in_t w;
    int       kind;
    int       span;
    int       lsum;
    int       wsum;
    int       dx;
    int       dy;
    w    = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      return w;
    end
    if ($urandom_range(0, 9) != 0) begin
      w.a_half_length = HW'($urandom_range(0, 2047));
      w.a_half_width  = HW'($urandom_range(0, 2047));
      w.b_half_length = HW'($urandom_range(0, 2047));
      w.b_half_width  = HW'($urandom_range(0, 2047));
    end
    if (kind < 75) begin
      // neighbours at random headings; non-unit headings kept for some
      if (kind < 60) begin
        unit_heading(w.a_cos, w.a_sin);
        unit_heading(w.b_cos, w.b_sin);
      end
      span = int'(w.a_half_length) + int'(w.a_half_width) +
             int'(w.b_half_length) + int'(w.b_half_width) + 1;
      dx = int'($urandom_range(0, 3 * span)) - (3 * span) / 2;
      dy = int'($urandom_range(0, 3 * span)) - (3 * span) / 2;
    end else begin
      // half-scale axis-aligned boxes set edge to edge, give or take one step
      w.a_half_length    = HW'($urandom_range(0, 4095));
      w.a_half_width     = HW'($urandom_range(0, 4095));
      w.b_half_length    = HW'($urandom_range(0, 4095));
      w.b_half_width     = HW'($urandom_range(0, 4095));
      w.b_half_length[0] = w.a_half_length[0];
      w.b_half_width[0]  = w.a_half_width[0];
      w.a_cos = TW'($urandom_range(0, 1) ? 16384 : -16384);
      w.b_cos = TW'($urandom_range(0, 1) ? 16384 : -16384);
      w.a_sin = '0;
      w.b_sin = '0;
      lsum = int'(w.a_half_length) + int'(w.b_half_length);
      wsum = int'(w.a_half_width) + int'(w.b_half_width);
      if ($urandom_range(0, 1)) begin
        dx = lsum / 2 + int'($urandom_range(0, 2)) - 1;
        dy = (int'($urandom_range(0, wsum)) * 2 - wsum) / 2;
      end else begin
        dy = wsum / 2 + int'($urandom_range(0, 2)) - 1;
        dx = (int'($urandom_range(0, lsum)) * 2 - lsum) / 2;
      end
      if ($urandom_range(0, 1)) begin
        dx = -dx;
      end
      if ($urandom_range(0, 1)) begin
        dy = -dy;
      end
    end
    w.b_center_x = CW'(int'(w.a_center_x) + dx);
    w.b_center_y = CW'(int'(w.a_center_y) + dy);
    return w;
  endfunction

  // Directed pairs: field extremes, degenerate boxes, touching edges
  task automatic run_directed_pairs();
    // identical boxes
    send_pair(mk_pair(0, 0, 32767, 0, 256, 128, 0, 0, 32767, 0, 256, 128));
    // opposite corners of the coordinate range, largest boxes
    send_pair(mk_pair(-8388608, -8388608, -32768, -32768, 65535, 65535,
                      8388607, 8388607, 32767, 32767, 65535, 65535));
    // same extreme centre, crossed segments
    send_pair(mk_pair(8388607, -8388608, 32767, -32768, 65535, 0,
                      8388607, -8388608, -32768, 32767, 0, 65535));
    // zero heading collapses both boxes to their centres
    send_pair(mk_pair(1000, -1000, 0, 0, 300, 300, 1000, -1000, 0, 0, 300, 300));
    // coincident points, then points one step apart
    send_pair(mk_pair(0, 0, 32767, 0, 0, 0, 0, 0, 0, 32767, 0, 0));
    send_pair(mk_pair(0, 0, 32767, 0, 0, 0, 1, 0, 32767, 0, 0, 0));
    // crossing segments, then a segment clear of the other
    send_pair(mk_pair(0, 0, 32767, 0, 512, 0, 0, 0, 0, 32767, 512, 0));
    send_pair(mk_pair(0, 0, 32767, 0, 512, 0, 0, 600, 0, 32767, 512, 0));
    // half-scale headings: edges touching in x, then one step apart
    send_pair(mk_pair(0, 0, 16384, 0, 512, 100, 512, 0, 16384, 0, 512, 100));
    send_pair(mk_pair(0, 0, 16384, 0, 512, 100, 513, 0, 16384, 0, 512, 100));
    // edges touching in y, then one step apart
    send_pair(mk_pair(0, 0, 0, 16384, 100, 512, 0, -100, 0, -16384, 100, 512));
    send_pair(mk_pair(0, 0, 0, 16384, 100, 512, 0, -101, 0, -16384, 100, 512));
    // diamond off a square's corner: bounds meet, a box axis separates
    send_pair(mk_pair(0, 0, 32767, 0, 256, 256, 440, 440, 23170, 23170, 256, 256));
    send_pair(mk_pair(0, 0, 32767, 0, 256, 256, 400, 400, 23170, 23170, 256, 256));
    // crossing diagonal bars
    send_pair(mk_pair(-5000, 3000, -23170, 23170, 2000, 40,
                      -4000, 3500, 23170, 23170, 2000, 40));
    // tiny and oversized non-unit headings
    send_pair(mk_pair(-1, -1, -1, -1, 65535, 65535, 0, 0, -1, -1, 65535, 65535));
    send_pair(mk_pair(0, 0, 32767, 32767, 30000, 10, 0, 0, -32768, 32767, 30000, 10));
    send_pair(mk_pair(100, 100, -32768, 0, 1, 1, -100, -100, 0, -32768, 1, 1));
  endtask

  initial begin
    rst_ni        <= 1'b0;
    pair_if.valid <= 1'b0;
    pair_if.data  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed_pairs();
    repeat (800) send_pair(random_pair());
    pair_if.valid <= 1'b0;

    // drain, then wait for anything stray
    wait (outstanding == 0);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("oriented_box_overlap_test_unit_tb: clean");
    end else begin
      $display("oriented_box_overlap_test_unit_tb: errors");
    end
    $finish;
  end

endmodule
